/* hdl/msnh_pkg.sv */
// Shared types and codes for the sustain-pedal note-off holder.
package msnh_pkg;

  localparam int PITCH_W     = 7;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_NOTE   = 3'd0;
  localparam logic [2:0] OP_VEL    = 3'd1;
  localparam logic [2:0] OP_PEDAL  = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] CMD_PASS    = 2'd0;
  localparam logic [1:0] CMD_HOLD    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] velocity;
  } cmd_t;

  // Position of the single set bit of a one-hot word.
  function automatic logic [4:0] onehot_index(input logic [31:0] oh);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hdl/midi_sustain_note_off_holder.sv */
// Top level of the sustain-pedal note-off holder.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | op, value
//   out     | out_valid/ out_ready | first_pitch, first_velocity, second_present,
//           |                      | second_pitch, last
//
// A pass-through note, a hold or a clear is handled in the back end; velocity
// and pedal-down items finish in the front end. A release walks the held map
// one 32-pitch word at a time, taking out each held pitch with a lowest-bit
// search and sending the pitches out in pairs. Reset empties the map and the
// command queue at once. A two-entry queue lets the front keep taking items
// while the back scans or the output register waits on out_ready.
module midi_sustain_note_off_holder
  import msnh_pkg::*;
#(
  parameter int NOTE_RANGE = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [DATA_W-1:0]  value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  first_pitch,
  output logic [DATA_W-1:0]  first_velocity,
  output logic               second_present,
  output logic [PITCH_W-1:0] second_pitch,
  output logic               last
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  msnh_front #(
    .NOTE_RANGE (NOTE_RANGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  msnh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  msnh_back #(
    .NOTE_RANGE (NOTE_RANGE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (pop_valid),
    .cmd_ready      (pop_ready),
    .cmd            (pop_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .first_pitch    (first_pitch),
    .first_velocity (first_velocity),
    .second_present (second_present),
    .second_pitch   (second_pitch),
    .last           (last)
  );

endmodule

/* hdl/msnh_front.sv */
// Front end: accepts items, tracks pedal and velocity, issues commands.
module msnh_front
  import msnh_pkg::*;
#(
  parameter int NOTE_RANGE = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op,
  input  logic [DATA_W-1:0] value,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  logic              pedal_down;
  logic [DATA_W-1:0] stored_velocity;
  logic              accept;
  logic              trackable;
  logic              has_cmd;

  assign in_ready  = push_ready;
  assign accept    = in_valid && push_ready;
  // Unsigned compare: negative pitches fail.
  assign trackable = value < DATA_W'(NOTE_RANGE);

  always_comb begin
    has_cmd           = 1'b0;
    push_cmd.kind     = CMD_PASS;
    push_cmd.value    = value;
    push_cmd.velocity = stored_velocity;
    case (op)
      OP_NOTE: begin
        has_cmd = 1'b1;
        if (stored_velocity == '0 && pedal_down && trackable) begin
          push_cmd.kind = CMD_HOLD;
        end
      end
      OP_PEDAL: begin
        if (value == '0) begin
          has_cmd       = 1'b1;
          push_cmd.kind = CMD_RELEASE;
        end
      end
      OP_FLUSH: begin
        has_cmd       = 1'b1;
        push_cmd.kind = CMD_RELEASE;
      end
      OP_CLEAR: begin
        has_cmd       = 1'b1;
        push_cmd.kind = CMD_CLEAR;
      end
      default: has_cmd = 1'b0;
    endcase
  end

  assign push_valid = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_down      <= 1'b0;
      stored_velocity <= '0;
    end else if (accept) begin
      if (op == OP_VEL) begin
        stored_velocity <= value;
      end
      if (op == OP_PEDAL) begin
        pedal_down <= (value != '0);
      end
    end
  end

endmodule

/* hdl/msnh_queue.sv */
// Short command queue between the front and back ends.
module msnh_queue
  import msnh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/msnh_back.sv */
// Back end: held-note map, release scan and result register.
module msnh_back
  import msnh_pkg::*;
#(
  parameter int NOTE_RANGE = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  first_pitch,
  output logic [DATA_W-1:0]  first_velocity,
  output logic               second_present,
  output logic [PITCH_W-1:0] second_pitch,
  output logic               last
);

  localparam int WORDS = (NOTE_RANGE + 31) / 32;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [31:0]        held_map [WORDS];
  logic [1:0]         state;
  logic [WIW-1:0]     wix;
  logic [31:0]        wd;
  logic               pending;
  logic [PITCH_W-1:0] first;
  logic               staged_valid;
  logic [PITCH_W-1:0] staged_first;
  logic [PITCH_W-1:0] staged_second;

  logic               out_free;
  logic [31:0]        low_bit;
  logic [4:0]         pos;
  logic [PITCH_W-1:0] cur_pitch;
  logic [WIW-1:0]     hold_word;
  logic [WIW-1:0]     rd_ix;
  logic [31:0]        rd_word;
  logic               take;
  logic               load_out;

  assign out_free  = !out_valid || out_ready;
  assign low_bit   = wd & (~wd + 32'd1);
  assign pos       = onehot_index(low_bit);
  assign cur_pitch = PITCH_W'({wix, pos});
  assign hold_word = WIW'(cmd.value[PITCH_W-1:5]);
  assign rd_ix     = (state == ST_IDLE) ? hold_word : wix;
  assign rd_word   = held_map[rd_ix];

  always_comb begin
    cmd_ready = 1'b0;
    if (state == ST_IDLE) begin
      cmd_ready = (cmd.kind == CMD_PASS) ? out_free : 1'b1;
    end
  end

  assign take = cmd_valid && cmd_ready;

  // Result register loads a new transfer this cycle.
  assign load_out = (state == ST_IDLE && take && cmd.kind == CMD_PASS)
                 || (state == ST_SCAN && wd != '0 && pending && staged_valid && out_free)
                 || (state == ST_END && out_free && (staged_valid || pending));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      pending      <= 1'b0;
      staged_valid <= 1'b0;
      wix          <= '0;
      for (int i = 0; i < WORDS; i++) begin
        held_map[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (cmd.kind)
              CMD_PASS: begin
                first_pitch    <= cmd.value;
                first_velocity <= cmd.velocity;
                second_present <= 1'b0;
                second_pitch   <= '0;
                last           <= 1'b1;
              end
              CMD_HOLD: begin
                held_map[hold_word] <= rd_word | (32'd1 << cmd.value[4:0]);
              end
              CMD_RELEASE: begin
                wix          <= '0;
                pending      <= 1'b0;
                staged_valid <= 1'b0;
                state        <= ST_LOAD;
              end
              CMD_CLEAR: begin
                for (int i = 0; i < WORDS; i++) begin
                  held_map[i] <= '0;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD: begin
          // Take the word out of the map; the scan empties it.
          wd            <= rd_word;
          held_map[wix] <= '0;
          state         <= ST_SCAN;
        end
        ST_SCAN: begin
          if (wd == '0) begin
            if (wix == WIW'(WORDS - 1)) begin
              state <= ST_END;
            end else begin
              wix   <= wix + 1'b1;
              state <= ST_LOAD;
            end
          end else if (!pending) begin
            first   <= cur_pitch;
            pending <= 1'b1;
            wd      <= wd & (wd - 32'd1);
          end else if (!staged_valid || out_free) begin
            // Hold the newest pair back until we know whether it is the final one.
            if (staged_valid) begin
              first_pitch    <= DATA_W'(staged_first);
              first_velocity <= '0;
              second_present <= 1'b1;
              second_pitch   <= staged_second;
              last           <= 1'b0;
            end
            staged_first  <= first;
            staged_second <= cur_pitch;
            staged_valid  <= 1'b1;
            pending       <= 1'b0;
            wd            <= wd & (wd - 32'd1);
          end
        end
        ST_END: begin
          if (staged_valid) begin
            if (out_free) begin
              first_pitch    <= DATA_W'(staged_first);
              first_velocity <= '0;
              second_present <= 1'b1;
              second_pitch   <= staged_second;
              last           <= !pending;
              staged_valid   <= 1'b0;
              if (!pending) begin
                state <= ST_IDLE;
              end
            end
          end else if (pending) begin
            if (out_free) begin
              first_pitch    <= DATA_W'(first);
              first_velocity <= '0;
              second_present <= 1'b0;
              second_pitch   <= '0;
              last           <= 1'b1;
              pending        <= 1'b0;
              state          <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
